/* sv/mdfe_pkg.sv */
// package for the marker delimited frame extractor
// holds marker patterns, widths, tracker state codes and the result struct
// no dependencies
package mdfe_pkg;

  localparam int MARKER_LEN = 8;
  localparam int PAT_DEPTH  = 16;
  localparam int CNT_W      = 4;
  localparam int BYTE_W     = 8;
  localparam int CAP_W      = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 16'd16384;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef byte_t pattern_t [PAT_DEPTH];

  localparam pattern_t START_PAT = '{
    8'h18, 8'h20, 8'h55, 8'hf2, 8'h5a, 8'hc0, 8'h4d, 8'haa,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam pattern_t END_PAT = '{
    8'h42, 8'h2c, 8'hd9, 8'he3, 8'hff, 8'ha0, 8'h11, 8'h01,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef enum logic [1:0] {
    SEARCH   = 2'b01,
    IN_FRAME = 2'b10
  } track_state_t;

  typedef struct packed {
    logic  valid;
    byte_t data;
    logic  fits;
    logic  done;
  } frame_result_t;

endpackage

/* sv/mdfe_tracker.sv */
// frame tracker: start/end marker match counters, frame byte count, capacity register
// decides the result for one byte per step
// depends on mdfe_pkg
module mdfe_tracker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  mdfe_pkg::byte_t            data,
  input  logic                       cfg_wr_en,
  input  logic [mdfe_pkg::CAP_W-1:0] cfg_wr_data,
  output mdfe_pkg::frame_result_t    res
);

  mdfe_pkg::track_state_t state, state_next;
  logic [mdfe_pkg::CNT_W-1:0] start_matched, start_matched_next;
  logic [mdfe_pkg::CNT_W-1:0] end_matched, end_matched_next;
  logic [mdfe_pkg::CAP_W-1:0] bytes_in_frame, bytes_in_frame_next;
  logic [mdfe_pkg::CAP_W-1:0] frame_capacity;
  logic [mdfe_pkg::CNT_W:0]   start_inc, end_inc;
  logic                       start_hit, end_hit, start_full, end_full, fits;

  assign start_hit  = (data == mdfe_pkg::START_PAT[start_matched]);
  assign end_hit    = (data == mdfe_pkg::END_PAT[end_matched]);
  assign start_inc  = {1'b0, start_matched} + {{mdfe_pkg::CNT_W{1'b0}}, 1'b1};
  assign end_inc    = {1'b0, end_matched} + {{mdfe_pkg::CNT_W{1'b0}}, 1'b1};
  assign start_full = start_hit &&
                      (start_inc >= (mdfe_pkg::CNT_W+1)'(mdfe_pkg::MARKER_LEN));
  assign end_full   = end_hit &&
                      (end_inc >= (mdfe_pkg::CNT_W+1)'(mdfe_pkg::MARKER_LEN));
  assign fits       = bytes_in_frame < frame_capacity;

  always_comb begin
    state_next          = state;
    start_matched_next  = start_matched;
    end_matched_next    = end_matched;
    bytes_in_frame_next = bytes_in_frame;
    res.valid           = 1'b0;
    res.data            = data;
    res.fits            = fits;
    res.done            = end_full;
    case (state)
      mdfe_pkg::SEARCH: begin
        if (start_full) begin
          state_next          = mdfe_pkg::IN_FRAME;
          start_matched_next  = '0;
          end_matched_next    = '0;
          bytes_in_frame_next = '0;
        end else if (start_hit) begin
          start_matched_next = start_inc[mdfe_pkg::CNT_W-1:0];
        end else begin
          start_matched_next = '0;
        end
      end
      mdfe_pkg::IN_FRAME: begin
        res.valid = 1'b1;
        if (end_full) begin
          state_next          = mdfe_pkg::SEARCH;
          start_matched_next  = '0;
          end_matched_next    = '0;
          bytes_in_frame_next = '0;
        end else begin
          end_matched_next = end_hit ? end_inc[mdfe_pkg::CNT_W-1:0] : '0;
          if (fits) begin
            bytes_in_frame_next = bytes_in_frame + (mdfe_pkg::CAP_W)'(1);
          end
        end
      end
      default: begin
        state_next = mdfe_pkg::SEARCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= mdfe_pkg::SEARCH;
      start_matched  <= '0;
      end_matched    <= '0;
      bytes_in_frame <= '0;
      frame_capacity <= mdfe_pkg::CAP_RESET;
    end else begin
      if (step) begin
        state          <= state_next;
        start_matched  <= start_matched_next;
        end_matched    <= end_matched_next;
        bytes_in_frame <= bytes_in_frame_next;
      end
      if (cfg_wr_en) begin
        frame_capacity <= cfg_wr_data;
      end
    end
  end

endmodule

/* sv/marker_delimited_frame_extractor.sv */
// marker delimited frame extractor top level: input register, tracker, result register
// depends on mdfe_pkg and mdfe_tracker
// a frame word goes from the input register through the tracker into the result register
// throughput: one word per cycle while the output is not stalled, set by the single tracker step between the registers
// a stalled output holds the result register and a full input register; words outside a frame leave no result
// reset: synchronous, clears valids and tracker state, capacity returns to 16384
module marker_delimited_frame_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  frame_byte,
  output logic        within_capacity,
  output logic        frame_end,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic                    in_reg_valid;
  mdfe_pkg::byte_t         in_reg_byte;
  logic                    advance, accept, step;
  mdfe_pkg::frame_result_t res;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_reg_valid && !advance;
  assign accept   = in_valid && !in_stall;
  assign step     = in_reg_valid && advance;

  mdfe_tracker u_tracker (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .data        (in_reg_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        in_reg_valid <= 1'b1;
      end else if (advance) begin
        in_reg_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= step && res.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg_byte <= rx_byte;
    end
    if (step) begin
      frame_byte      <= res.data;
      within_capacity <= res.fits;
      frame_end       <= res.done;
    end
  end

endmodule

/* tb/tb_marker_delimited_frame_extractor.sv */
// testbench for marker_delimited_frame_extractor: directed and random byte streams
// a local frame tracker predicts each frame word, a checker compares the output words
// depends on mdfe_pkg and the marker_delimited_frame_extractor rtl
module tb_marker_delimited_frame_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  typedef mdfe_pkg::byte_t byte_t;

  localparam int MARK_LEN = 8;
  localparam byte_t OPEN_MARK [MARK_LEN] = '{
    8'h18, 8'h20, 8'h55, 8'hf2, 8'h5a, 8'hc0, 8'h4d, 8'haa
  };
  localparam byte_t CLOSE_MARK [MARK_LEN] = '{
    8'h42, 8'h2c, 8'hd9, 8'he3, 8'hff, 8'ha0, 8'h11, 8'h01
  };

  typedef struct packed {
    byte_t data;
    logic  fits;
    logic  closes;
  } frame_word_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  byte_t       rx_byte;
  logic        out_valid;
  logic        out_stall;
  byte_t       frame_byte;
  logic        within_capacity;
  logic        frame_end;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  frame_word_t expected_words [$];

  logic        in_frame;
  int          open_count;
  int          close_count;
  logic [15:0] kept_count;
  logic [15:0] capacity;

  int mismatch_count;
  int words_sent;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_hold_left;

  marker_delimited_frame_extractor u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .frame_byte      (frame_byte),
    .within_capacity (within_capacity),
    .frame_end       (frame_end),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  function void track_word(input byte_t b);
    frame_word_t w;
    if (!in_frame) begin
      if (b == OPEN_MARK[open_count]) open_count++;
      else open_count = 0;
      if (open_count >= MARK_LEN) begin
        in_frame    = 1'b1;
        open_count  = 0;
        close_count = 0;
        kept_count  = '0;
      end
    end else begin
      if (b == CLOSE_MARK[close_count]) close_count++;
      else close_count = 0;
      w.data   = b;
      w.fits   = kept_count < capacity;
      w.closes = close_count >= MARK_LEN;
      if (w.fits) kept_count++;
      if (w.closes) begin
        in_frame    = 1'b0;
        open_count  = 0;
        close_count = 0;
        kept_count  = '0;
      end
      expected_words.push_back(w);
    end
  endfunction

  // receiver side: random stall, or a counted hold-off when requested
  always @(negedge clk) begin
    if (stall_hold_left > 0) begin
      out_stall <= 1'b1;
      stall_hold_left = stall_hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_words
    frame_word_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", frame_byte));
      end else begin
        want = expected_words.pop_front();
        if (frame_byte !== want.data)
          report_mismatch($sformatf("frame_byte %h, want %h", frame_byte, want.data));
        if (within_capacity !== want.fits)
          report_mismatch($sformatf("within_capacity %b, want %b on %h",
                                    within_capacity, want.fits, want.data));
        if (frame_end !== want.closes)
          report_mismatch($sformatf("frame_end %b, want %b on %h",
                                    frame_end, want.closes, want.data));
      end
    end
  end

  task send_word(input byte_t b);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    track_word(b);
    words_sent++;
  endtask

  task send_open_prefix(input int n);
    for (int i = 0; i < n; i++) send_word(OPEN_MARK[i]);
  endtask

  task send_close_prefix(input int n);
    for (int i = 0; i < n; i++) send_word(CLOSE_MARK[i]);
  endtask

  // sender pauses until every expected word is out and the pipeline is empty
  task wait_frame_words_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_capacity(input logic [15:0] value);
    wait_frame_words_done();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    capacity = value;
  endtask

  task test_start_search();
    // a repeated first marker byte is tested before a full start marker
    send_open_prefix(1);
    send_word(8'h18);
    send_word(8'h20);
    send_open_prefix(MARK_LEN);
  endtask

  task test_capacity_lowered();
    send_word(8'h00);
    send_word(8'hff);
    write_capacity(16'd1);
    send_word(8'h5a);
  endtask

  task test_frame_end();
    send_close_prefix(2);
    send_word(8'h42);
    send_close_prefix(MARK_LEN);
    // search resumes on the word right after the end marker
    send_open_prefix(MARK_LEN);
    send_close_prefix(MARK_LEN);
  endtask

  task test_output_hold();
    write_capacity(16'd40);
    send_open_prefix(MARK_LEN);
    stall_hold_left = 150;
    for (int i = 0; i < 60; i++) send_word(byte_t'($urandom));
    send_close_prefix(MARK_LEN);
    wait_frame_words_done();
  endtask

  task test_random_frames(input int n_words, input logic [15:0] cap);
    int first;
    int len;
    write_capacity(cap);
    first = words_sent;
    while (words_sent - first < n_words) begin
      repeat ($urandom_range(0, 4)) send_word(byte_t'($urandom));
      if ($urandom_range(99) < 20) begin
        send_open_prefix($urandom_range(1, MARK_LEN - 1));
        send_word(byte_t'($urandom));
      end
      send_open_prefix(MARK_LEN);
      len = ($urandom_range(99) < 5) ? $urandom_range(40, 80) : $urandom_range(0, 24);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 10) send_close_prefix($urandom_range(1, MARK_LEN - 1));
        send_word(byte_t'($urandom));
      end
      // now and then the frame is left open and runs into the next one
      if ($urandom_range(99) < 90) send_close_prefix(MARK_LEN);
    end
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    rx_byte         = '0;
    out_stall       = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_frame        = 1'b0;
    open_count      = 0;
    close_count     = 0;
    kept_count      = '0;
    capacity        = mdfe_pkg::CAP_RESET;
    mismatch_count  = 0;
    words_sent      = 0;
    stall_hold_left = 0;
    send_idle_pct   = 30;
    recv_idle_pct   = 58;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_start_search();
    test_capacity_lowered();
    test_frame_end();
    test_output_hold();

    test_random_frames(200, 16'd0);
    test_random_frames(120, 16'd65535);
    send_idle_pct = 58;
    recv_idle_pct = 30;
    test_random_frames(200, 16'($urandom_range(1, 24)));
    test_random_frames(120, 16'd3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(300, 16'($urandom_range(1, 40)));

    wait_frame_words_done();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
